// ===== rtl/core/aut_pkg.sv =====
package aut_pkg;

  localparam int TableEntries = 1024;
  localparam int PtrW   = 64;
  localparam int SizeW  = 48;
  localparam int StampW = 64;
  localparam int StatW  = 64;
  localparam int CountW = 32;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_FREED = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_REUSED   = 3'd1,
    ST_REPLACED = 3'd2,
    ST_FREED    = 3'd3,
    ST_DOUBLE   = 3'd4,
    ST_UNMATCH  = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    mark_e              mark;
    logic [PtrW-1:0]    tag;
    logic [SizeW-1:0]   bytes;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [SizeW-1:0]   old_bytes;
  } probe_res_t;

  typedef enum logic [1:0] {
    P_CLEAR = 2'd0,
    P_IDLE  = 2'd1,
    P_PROBE = 2'd2
  } probe_state_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOOK = 2'd1,
    S_STAT = 2'd2,
    S_PEAK = 2'd3
  } top_state_e;

endpackage

// ===== rtl/core/aut_probe.sv =====
module aut_probe #(
  parameter int TABLE_ENTRIES = aut_pkg::TableEntries
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_i,
  input  logic                      kind_i,
  input  logic [aut_pkg::PtrW-1:0]  pointer_i,
  input  logic [aut_pkg::SizeW-1:0] block_size_i,
  output logic                      ready_o,
  output logic                      done_o,
  output aut_pkg::probe_res_t       res_o
);
  import aut_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

  probe_state_e state_q, state_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] next_addr;
  logic [IW-1:0] hash_raw;
  logic [IW-1:0] hash_idx;
  logic          kind_q;
  logic [PtrW-1:0]  ptr_q;
  logic [SizeW-1:0] size_q;
  entry_t        table_mem [TABLE_ENTRIES];
  entry_t        rdata_q;
  entry_t        wdata;
  logic [IW-1:0] wr_addr;
  logic          we;
  logic          hit;
  logic          empty;

  // fold the pointer into an index
  always_comb begin
    hash_raw = '0;
    for (int i = 0; i < PtrW; i++) begin
      hash_raw[i % IW] = hash_raw[i % IW] ^ pointer_i[i];
    end
    if ({1'b0, hash_raw} >= (IW+1)'(TABLE_ENTRIES)) begin
      hash_idx = IW'({1'b0, hash_raw} - (IW+1)'(TABLE_ENTRIES));
    end else begin
      hash_idx = hash_raw;
    end
  end

  assign next_addr = (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
  assign hit   = (rdata_q.mark != MARK_EMPTY) && (rdata_q.tag == ptr_q);
  assign empty = (rdata_q.mark == MARK_EMPTY);

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    rd_addr = addr_q;
    we      = 1'b0;
    wr_addr = addr_q;
    wdata   = '{mark: MARK_LIVE, tag: ptr_q, bytes: size_q};
    done_o  = 1'b0;
    res_o   = '{status: ST_UNMATCH, old_bytes: rdata_q.bytes};
    case (state_q)
      P_CLEAR: begin
        we      = 1'b1;
        wdata   = '{mark: MARK_EMPTY, tag: '0, bytes: '0};
        addr_d  = next_addr;
        if (addr_q == LastIdx) begin
          state_d = P_IDLE;
        end
      end
      P_IDLE: begin
        rd_addr = hash_idx;
        if (req_i) begin
          addr_d  = hash_idx;
          cnt_d   = '0;
          state_d = P_PROBE;
        end
      end
      P_PROBE: begin
        if (hit) begin
          done_o  = 1'b1;
          state_d = P_IDLE;
          if (kind_q == KIND_ALLOC) begin
            we = 1'b1;
            res_o.status = (rdata_q.mark == MARK_LIVE) ? ST_REPLACED : ST_REUSED;
          end else if (rdata_q.mark == MARK_LIVE) begin
            we    = 1'b1;
            wdata = '{mark: MARK_FREED, tag: rdata_q.tag, bytes: rdata_q.bytes};
            res_o.status = ST_FREED;
          end else begin
            res_o.status = ST_DOUBLE;
          end
        end else if (empty) begin
          done_o  = 1'b1;
          state_d = P_IDLE;
          if (kind_q == KIND_ALLOC) begin
            we = 1'b1;
            res_o.status = ST_NEW;
          end
        end else if (cnt_q == LastIdx) begin
          done_o  = 1'b1;
          state_d = P_IDLE;
          res_o.status = (kind_q == KIND_ALLOC) ? ST_FULL : ST_UNMATCH;
        end else begin
          // advance to the next slot
          addr_d  = next_addr;
          rd_addr = next_addr;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  assign ready_o = (state_q == P_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_CLEAR;
      addr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == P_IDLE && req_i) begin
      kind_q <= kind_i;
      ptr_q  <= pointer_i;
      size_q <= block_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[wr_addr] <= wdata;
    end
    rdata_q <= table_mem[rd_addr];
  end

endmodule

// ===== rtl/core/allocation_usage_tracker.sv =====
// Allocation usage tracker.
// Input channel: an event (kind_i, pointer_i, block_size_i, timestamp_i) is
// taken at a rising edge with start high and busy low. kind_i is 0 for an
// allocation and 1 for a free; block_size_i is ignored for frees.
// Result channel: done_o is high for exactly one cycle per event, with
// status_o and all running statistics valid in that cycle. The receiver
// cannot stall, so results never back up.
// Each event takes 1 to TABLE_ENTRIES hash probes. The pointer table is one
// synchronous memory with linear probing from a folded-pointer hash; each
// probe is one read, then the S_STAT and S_PEAK states update the statistics
// and the peak. One event is in flight at a time; a new event may start in
// the cycle done_o is high.
// Reset: all statistics clear at once; the table memory is then swept empty,
// one entry a cycle, and busy is high while the sweep runs.
module allocation_usage_tracker #(
  parameter int TABLE_ENTRIES = aut_pkg::TableEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [aut_pkg::PtrW-1:0]    pointer_i,
  input  logic [aut_pkg::SizeW-1:0]   block_size_i,
  input  logic [aut_pkg::StampW-1:0]  timestamp_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [aut_pkg::StatW-1:0]   usage_now_o,
  output logic [aut_pkg::StatW-1:0]   usage_peak_o,
  output logic [aut_pkg::CountW-1:0]  alloc_count_o,
  output logic [aut_pkg::CountW-1:0]  free_count_o,
  output logic [aut_pkg::StatW-1:0]   bytes_alloc_total_o,
  output logic [aut_pkg::StatW-1:0]   bytes_free_total_o,
  output logic [aut_pkg::StatW-1:0]   live_bytes_o,
  output logic [aut_pkg::StampW-1:0]  first_alloc_stamp_o,
  output logic [aut_pkg::StampW-1:0]  last_free_stamp_o
);
  import aut_pkg::*;

  top_state_e state_q, state_d;
  logic             accept;
  logic             probe_ready;
  logic             probe_done;
  probe_res_t       probe_res;
  probe_res_t       res_q;
  logic             kind_q;
  logic [SizeW-1:0] size_q;
  logic [StampW-1:0] stamp_q;
  logic             done_q, done_d;

  logic [StatW-1:0]  usage_q, usage_d, peak_q, peak_d;
  logic [CountW-1:0] acnt_q, acnt_d, fcnt_q, fcnt_d;
  logic [StatW-1:0]  abytes_q, abytes_d, fbytes_q, fbytes_d, live_q, live_d;
  logic [StampW-1:0] first_q, first_d, last_q, last_d;
  logic [StatW:0]    usage_sum, abytes_sum, fbytes_sum;
  logic [StatW-1:0]  old_ext, size_ext;

  assign busy   = (state_q != S_IDLE) || !probe_ready;
  assign accept = start && !busy;

  aut_probe #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (accept),
    .kind_i      (kind_i),
    .pointer_i   (pointer_i),
    .block_size_i(block_size_i),
    .ready_o     (probe_ready),
    .done_o      (probe_done),
    .res_o       (probe_res)
  );

  assign old_ext    = StatW'(res_q.old_bytes);
  assign size_ext   = StatW'(size_q);
  assign usage_sum  = {1'b0, usage_q} + {1'b0, size_ext};
  assign abytes_sum = {1'b0, abytes_q} + {1'b0, size_ext};
  assign fbytes_sum = {1'b0, fbytes_q} + {1'b0, old_ext};

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    usage_d  = usage_q;
    peak_d   = peak_q;
    acnt_d   = acnt_q;
    fcnt_d   = fcnt_q;
    abytes_d = abytes_q;
    fbytes_d = fbytes_q;
    live_d   = live_q;
    first_d  = first_q;
    last_d   = last_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (probe_done) begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        state_d = S_PEAK;
        if (kind_q == KIND_ALLOC) begin
          acnt_d   = (acnt_q == '1) ? acnt_q : acnt_q + 1'b1;
          abytes_d = abytes_sum[StatW] ? '1 : abytes_sum[StatW-1:0];
          usage_d  = usage_sum[StatW] ? '1 : usage_sum[StatW-1:0];
          if (first_q == '0) begin
            first_d = stamp_q;
          end
          case (res_q.status)
            ST_REPLACED: live_d = live_q - old_ext + size_ext;
            ST_NEW, ST_REUSED: live_d = live_q + size_ext;
            default: live_d = live_q;
          endcase
        end else begin
          fcnt_d = (fcnt_q == '1) ? fcnt_q : fcnt_q + 1'b1;
          last_d = stamp_q;
          if (res_q.status == ST_FREED) begin
            fbytes_d = fbytes_sum[StatW] ? '1 : fbytes_sum[StatW-1:0];
            usage_d  = (usage_q > old_ext) ? usage_q - old_ext : '0;
            live_d   = live_q - old_ext;
          end
        end
      end
      S_PEAK: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (usage_q > peak_q) begin
          peak_d = usage_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      usage_q  <= '0;
      peak_q   <= '0;
      acnt_q   <= '0;
      fcnt_q   <= '0;
      abytes_q <= '0;
      fbytes_q <= '0;
      live_q   <= '0;
      first_q  <= '0;
      last_q   <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      usage_q  <= usage_d;
      peak_q   <= peak_d;
      acnt_q   <= acnt_d;
      fcnt_q   <= fcnt_d;
      abytes_q <= abytes_d;
      fbytes_q <= fbytes_d;
      live_q   <= live_d;
      first_q  <= first_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      size_q  <= block_size_i;
      stamp_q <= timestamp_i;
    end
    if (state_q == S_LOOK && probe_done) begin
      res_q <= probe_res;
    end
  end

  assign done_o              = done_q;
  assign status_o            = res_q.status;
  assign usage_now_o         = usage_q;
  assign usage_peak_o        = peak_q;
  assign alloc_count_o       = acnt_q;
  assign free_count_o        = fcnt_q;
  assign bytes_alloc_total_o = abytes_q;
  assign bytes_free_total_o  = fbytes_q;
  assign live_bytes_o        = live_q;
  assign first_alloc_stamp_o = first_q;
  assign last_free_stamp_o   = last_q;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aut_pkg::*;

  localparam int NumEntries = aut_pkg::TableEntries;
  localparam int PoolSize   = 40;
  localparam longint CycleLimit = 10_000_000;

  typedef struct packed {
    status_e             status;
    logic [StatW-1:0]    usage_now;
    logic [StatW-1:0]    usage_peak;
    logic [CountW-1:0]   alloc_count;
    logic [CountW-1:0]   free_count;
    logic [StatW-1:0]    alloc_total;
    logic [StatW-1:0]    free_total;
    logic [StatW-1:0]    live;
    logic [StampW-1:0]   first_stamp;
    logic [StampW-1:0]   last_stamp;
  } tally_t;

  typedef struct {
    kind_e               kind;
    logic [PtrW-1:0]     ptr;
    logic [SizeW-1:0]    size;
    logic [StampW-1:0]   stamp;
    bit                  typed;
    status_e             status;
  } event_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic kind_i = 1'b0;
  logic [PtrW-1:0]   pointer_i = '0;
  logic [SizeW-1:0]  block_size_i = '0;
  logic [StampW-1:0] timestamp_i = '0;
  logic              done_o;
  logic [2:0]        status_o;
  logic [StatW-1:0]  usage_now_o, usage_peak_o, bytes_alloc_total_o, bytes_free_total_o;
  logic [StatW-1:0]  live_bytes_o;
  logic [CountW-1:0] alloc_count_o, free_count_o;
  logic [StampW-1:0] first_alloc_stamp_o, last_free_stamp_o;

  allocation_usage_tracker dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor copy of the pointer table and the statistics
  logic [PtrW-1:0]  ptr_tag  [NumEntries];
  logic [SizeW-1:0] ptr_bytes[NumEntries];
  mark_e            ptr_mark [NumEntries];
  tally_t           tally;
  int               entries_used;

  tally_t pending_tallies[$];
  int     mismatches;
  int     status_hits[7];
  int     items_sent;
  bit     idling_on;
  longint cycles;

  logic [PtrW-1:0] pool[PoolSize];
  logic [PtrW-1:0] fill_ptrs[$];

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] inc_sat(logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic tally_t track_event(kind_e k, logic [PtrW-1:0] p,
                                         logic [SizeW-1:0] sz, logic [StampW-1:0] ts);
    int hit;
    int slot;
    hit = -1;
    slot = -1;
    for (int i = 0; i < NumEntries; i++) begin
      if (ptr_mark[i] != MARK_EMPTY && ptr_tag[i] == p) begin
        hit = i;
        break;
      end
    end
    if (k == KIND_ALLOC) begin
      tally.alloc_count = inc_sat(tally.alloc_count);
      tally.alloc_total = add_sat(tally.alloc_total, 64'(sz));
      if (tally.first_stamp == '0) tally.first_stamp = ts;
      if (hit >= 0) begin
        slot = hit;
        if (ptr_mark[hit] == MARK_LIVE) begin
          tally.status = ST_REPLACED;
          tally.live = tally.live - 64'(ptr_bytes[hit]);
        end else begin
          tally.status = ST_REUSED;
        end
      end else begin
        for (int i = 0; i < NumEntries; i++) begin
          if (ptr_mark[i] == MARK_EMPTY) begin
            slot = i;
            break;
          end
        end
        tally.status = (slot >= 0) ? ST_NEW : ST_FULL;
        if (slot >= 0) entries_used++;
      end
      if (slot >= 0) begin
        ptr_tag[slot] = p;
        ptr_bytes[slot] = sz;
        ptr_mark[slot] = MARK_LIVE;
        tally.live = tally.live + 64'(sz);
      end
      tally.usage_now = add_sat(tally.usage_now, 64'(sz));
      if (tally.usage_now > tally.usage_peak) tally.usage_peak = tally.usage_now;
    end else begin
      tally.free_count = inc_sat(tally.free_count);
      tally.last_stamp = ts;
      if (hit < 0) begin
        tally.status = ST_UNMATCH;
      end else if (ptr_mark[hit] == MARK_FREED) begin
        tally.status = ST_DOUBLE;
      end else begin
        tally.status = ST_FREED;
        tally.free_total = add_sat(tally.free_total, 64'(ptr_bytes[hit]));
        tally.usage_now = (tally.usage_now > 64'(ptr_bytes[hit])) ?
                          tally.usage_now - 64'(ptr_bytes[hit]) : '0;
        tally.live = tally.live - 64'(ptr_bytes[hit]);
        ptr_mark[hit] = MARK_FREED;
      end
    end
    return tally;
  endfunction

  // drive one item, hold it until taken, then log its expected tally
  task automatic send_event(kind_e k, logic [PtrW-1:0] p, logic [SizeW-1:0] sz,
                            logic [StampW-1:0] ts, bit typed = 0,
                            status_e typed_status = ST_NEW);
    tally_t t;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= k;
    pointer_i <= p;
    block_size_i <= sz;
    timestamp_i <= ts;
    do @(posedge clk_i); while (busy);
    t = track_event(k, p, sz, ts);
    if (typed) t.status = typed_status;
    pending_tallies.insert(pending_tallies.size(), t);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_tallies.size());
      $display("allocation_usage_tracker test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && done_o) begin
      if (pending_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = pending_tallies.pop_front();
        if (status_o <= 3'd6) status_hits[status_o]++;
        if (want.status != status_e'(status_o) || want.usage_now != usage_now_o ||
            want.usage_peak != usage_peak_o || want.alloc_count != alloc_count_o ||
            want.free_count != free_count_o || want.alloc_total != bytes_alloc_total_o ||
            want.free_total != bytes_free_total_o || want.live != live_bytes_o ||
            want.first_stamp != first_alloc_stamp_o ||
            want.last_stamp != last_free_stamp_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d:", cycles);
            $display("  exp st=%0d now=%h pk=%h ac=%0d fc=%0d at=%h ft=%h lv=%h f=%h l=%h",
                     want.status, want.usage_now, want.usage_peak, want.alloc_count,
                     want.free_count, want.alloc_total, want.free_total, want.live,
                     want.first_stamp, want.last_stamp);
            $display("  got st=%0d now=%h pk=%h ac=%0d fc=%0d at=%h ft=%h lv=%h f=%h l=%h",
                     status_o, usage_now_o, usage_peak_o, alloc_count_o, free_count_o,
                     bytes_alloc_total_o, bytes_free_total_o, live_bytes_o,
                     first_alloc_stamp_o, last_free_stamp_o);
          end
        end
      end
    end
  end

  initial begin
    event_row_t script[$];
    logic [PtrW-1:0] p;
    logic [SizeW-1:0] sz;
    logic [StampW-1:0] ts;
    int full_seen;
    int pick;

    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    entries_used = 0;
    idling_on = 1'b1;
    tally = '0;
    foreach (ptr_mark[i]) ptr_mark[i] = MARK_EMPTY;
    foreach (status_hits[i]) status_hits[i] = 0;

    script = '{
      '{KIND_FREE,  64'h0,        48'h0,      '1,         1, ST_UNMATCH},
      '{KIND_ALLOC, 64'h0,        48'h0,      64'h0,      1, ST_NEW},
      '{KIND_ALLOC, '1,           '1,         64'h5,      1, ST_NEW},
      '{KIND_ALLOC, '1,           48'h1,      '1,         1, ST_REPLACED},
      '{KIND_FREE,  '1,           '1,         64'h10,     1, ST_FREED},
      '{KIND_FREE,  '1,           48'h0,      64'h11,     1, ST_DOUBLE},
      '{KIND_ALLOC, '1,           48'h123,    64'h12,     1, ST_REUSED},
      '{KIND_FREE,  64'h0,        48'h0,      64'h0,      1, ST_FREED},
      '{KIND_FREE,  {32{2'b01}},  48'h0,      {32{2'b10}}, 1, ST_UNMATCH},
      '{KIND_ALLOC, {32{2'b10}},  {24{2'b10}}, {32{2'b01}}, 1, ST_NEW},
      '{KIND_ALLOC, {32{2'b01}},  {24{2'b01}}, {32{2'b10}}, 1, ST_NEW},
      '{KIND_FREE,  {32{2'b10}},  '1,         '1,         1, ST_FREED},
      '{KIND_ALLOC, {32{2'b10}},  '1,         64'h1,      1, ST_REUSED},
      '{KIND_ALLOC, {32{2'b01}},  '1,         64'h2,      1, ST_REPLACED},
      '{KIND_ALLOC, 64'h8000_0000_0000_0000, '1, 64'h3,   0, ST_NEW},
      '{KIND_FREE,  {32{2'b01}},  48'h0,      64'h4,      0, ST_NEW},
      '{KIND_FREE,  '1,           48'h0,      64'h5,      0, ST_NEW},
      '{KIND_FREE,  64'h8000_0000_0000_0000, 48'h0, 64'h0, 0, ST_NEW}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i])
      send_event(script[i].kind, script[i].ptr, script[i].size, script[i].stamp,
                 script[i].typed, script[i].status);

    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    pool[0] = '0;
    pool[1] = '1;

    // random traffic over a small pointer pool: reuse, replace and double frees
    for (int n = 0; n < 70; n++) begin
      if (n == 35) drain();
      pick = $urandom_range(0, 99);
      p = pool[$urandom_range(0, PoolSize - 1)];
      sz = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom}) :
                                         48'($urandom_range(0, 4096));
      ts = {$urandom, $urandom};
      if (pick < 55) send_event(KIND_ALLOC, p, sz, ts);
      else if (pick < 93) send_event(KIND_FREE, p, sz, ts);
      else send_event(KIND_FREE, {$urandom, $urandom}, sz, ts);
    end

    // fill the table with fresh pointers until allocations overflow it
    full_seen = 0;
    while (full_seen < 25) begin
      pick = $urandom_range(0, 99);
      sz = 48'($urandom_range(1, 65535));
      ts = {$urandom, $urandom};
      if (pick < 85 || fill_ptrs.size() == 0) begin
        p = {16'hF11D, 16'($urandom), 32'(fill_ptrs.size())};
        fill_ptrs.insert(fill_ptrs.size(), p);
        if (entries_used >= NumEntries) begin
          full_seen++;
          idling_on = 1'b0;
        end
        send_event(KIND_ALLOC, p, sz, ts);
      end else if (pick < 95) begin
        send_event(KIND_FREE, fill_ptrs[$urandom_range(0, fill_ptrs.size() - 1)], sz, ts);
      end else begin
        send_event(KIND_ALLOC, pool[$urandom_range(0, PoolSize - 1)], sz, ts);
      end
    end

    drain();
    repeat (2 * NumEntries + 20) @(posedge clk_i);
    mismatches += pending_tallies.size();

    $display("sent %0d items; status counts new %0d reused %0d replaced %0d freed %0d",
             items_sent, status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    $display("double free %0d, unmatched %0d, table full %0d; %0d mismatches",
             status_hits[4], status_hits[5], status_hits[6], mismatches);
    if (mismatches == 0) begin
      $display("allocation_usage_tracker test passed");
    end else begin
      $display("allocation_usage_tracker test failed");
    end
    $finish;
  end

endmodule
